/* rtl/csus_pkg.sv */
// Shared types and constants for the CAN signal unpack and scale block.
// No dependencies; imported by every module of the block.
package csus_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_START_BIT      = 3'd0;
  localparam logic [2:0] REG_BIT_LENGTH     = 3'd1;
  localparam logic [2:0] REG_MOTOROLA_ORDER = 3'd2;
  localparam logic [2:0] REG_SIGNED_MODE    = 3'd3;
  localparam logic [2:0] REG_SCALE_FACTOR   = 3'd4;
  localparam logic [2:0] REG_SCALE_OFFSET   = 3'd5;

  localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] PHYS_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] PHYS_MIN = 64'h8000_0000_0000_0000;

  // Width of the full-precision product and sum
  localparam int SUM_W = 98;

  // Register file contents
  typedef struct packed {
    logic [5:0]         start_bit;
    logic [6:0]         bit_length;
    logic               motorola_order;
    logic               signed_mode;
    logic signed [31:0] scale_factor;
    logic signed [63:0] scale_offset;
  } cfg_t;

endpackage

/* rtl/csus_extract.sv */
// Signal extraction: byte-order aware barrel shift, then length mask and
// sign extension. Two register stages. Depends on csus_pkg.
module csus_extract import csus_pkg::*; #(
  parameter int FRAME_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] raw_value
);

  localparam logic [63:0] FRAME_MASK = ALL_ONES >> (64 - FRAME_BYTES * 8);

  logic        v1, v2;
  logic        en1, en2;
  logic [63:0] acc;
  logic [63:0] raw;

  logic [63:0] frame, rev, shift_src, acc_next;
  logic [5:0]  shift_amt;
  logic [6:0]  len;
  logic [5:0]  sign_pos;
  logic [63:0] len_mask, raw_next;
  logic        sign_bit;

  // Stall control: a stage moves when empty or when its successor moves
  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // Stage 1: bytes outside the frame read as zero; Motorola order reverses
  // the bytes so that both orders become one right shift
  always_comb begin
    frame = payload & FRAME_MASK;
    for (int j = 0; j < 8; j++) begin
      rev[8*j +: 8] = frame[8*(7-j) +: 8];
    end
    if (cfg.motorola_order) begin
      shift_src = rev;
      shift_amt = {~cfg.start_bit[5:3], cfg.start_bit[2:0]};
    end else begin
      shift_src = frame;
      shift_amt = cfg.start_bit;
    end
    acc_next = shift_src >> shift_amt;
  end

  // Stage 2: length mask (length 0 gives an empty signal) and sign extension
  always_comb begin
    len      = (cfg.bit_length > 7'd64) ? 7'd64 : cfg.bit_length;
    len_mask = ALL_ONES >> (7'd64 - len);
    sign_pos = 6'(len - 7'd1);
    sign_bit = cfg.signed_mode && (len != 7'd0) && acc[sign_pos];
    raw_next = (acc & len_mask) | (sign_bit ? ~len_mask : 64'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
    if (en1 && in_valid) acc <= acc_next;
    if (en2 && v1)       raw <= raw_next;
  end

  assign out_valid = v2;
  assign raw_value = raw;

endmodule

/* rtl/csus_mac.sv */
// Exact multiply-add: raw times Q16.16 factor plus Q48.16 offset at full
// precision. Three stages: partial products, combine, offset add.
// Depends on csus_pkg.
module csus_mac import csus_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [63:0]             raw_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [63:0]             raw_out,
  output logic signed [SUM_W-1:0] sum
);

  logic               v3, v4, v5;
  logic               en3, en4, en5;
  logic signed [64:0] p0, p1;
  logic signed [SUM_W-1:0] prod;
  logic [63:0]        raw3, raw4, raw5;
  logic signed [SUM_W-1:0] sum5;

  logic signed [32:0] lo_op, hi_op;
  logic signed [64:0] p0_next, p1_next;
  logic signed [SUM_W-1:0] prod_next, sum_next;

  assign en5      = !v5 || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign in_ready = en3;

  // Stage 3: split the 65-bit signed raw into an unsigned low half and a
  // signed high half, two 33x32 multiplies
  always_comb begin
    lo_op   = $signed({1'b0, raw_in[31:0]});
    hi_op   = $signed({cfg.signed_mode & raw_in[63], raw_in[63:32]});
    p0_next = lo_op * cfg.scale_factor;
    p1_next = hi_op * cfg.scale_factor;
  end

  // Stage 4: recombine partial products
  assign prod_next = $signed({p1[64], p1, 32'd0}) + $signed({{33{p0[64]}}, p0});

  // Stage 5: add the sign-extended offset
  assign sum_next = prod + $signed({{(SUM_W-64){cfg.scale_offset[63]}}, cfg.scale_offset});

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en3) v3 <= in_valid;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
    if (en3 && in_valid) begin
      p0   <= p0_next;
      p1   <= p1_next;
      raw3 <= raw_in;
    end
    if (en4 && v3) begin
      prod <= prod_next;
      raw4 <= raw3;
    end
    if (en5 && v4) begin
      sum5 <= sum_next;
      raw5 <= raw4;
    end
  end

  assign out_valid = v5;
  assign raw_out   = raw5;
  assign sum       = sum5;

endmodule

/* rtl/can_signal_unpack_scale_unit.sv */
// Top level of the CAN signal unpack and scale block: register file,
// output saturation stage and the stream ports.
// Depends on csus_pkg, csus_extract and csus_mac.
// Throughput: one beat per cycle; six register stages, each with its own
// valid bit, so bubbles fill in and a stall only holds the stages behind it.
// Reset (synchronous): clears all valid bits and loads the register defaults
// (start bit 0, length 8, Intel order, unsigned, factor 1.0, offset 0).
module can_signal_unpack_scale_unit import csus_pkg::*; #(
  parameter int FRAME_BYTES = 8
) (
  input  logic         clk,
  input  logic         rst,
  // configuration write port
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // [63:0] payload
  // output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // [63:0] raw_value, [127:64] scaled_value
  output logic [0:0]   m_tuser    // [0] saturated
);

  cfg_t cfg;

  logic        ex_valid, ex_ready;
  logic [63:0] ex_raw;
  logic        mac_valid, mac_ready;
  logic [63:0] mac_raw;
  logic signed [SUM_W-1:0] mac_sum;

  logic        v6, en6;
  logic [63:0] raw_value, scaled_value;
  logic        saturated;
  logic        sat_next;
  logic [63:0] phys_next;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_bit      <= 6'd0;
      cfg.bit_length     <= 7'd8;
      cfg.motorola_order <= 1'b0;
      cfg.signed_mode    <= 1'b0;
      cfg.scale_factor   <= 32'sd65536;
      cfg.scale_offset   <= 64'sd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_START_BIT:      cfg.start_bit      <= cfg_data[5:0];
        REG_BIT_LENGTH:     cfg.bit_length     <= cfg_data[6:0];
        REG_MOTOROLA_ORDER: cfg.motorola_order <= cfg_data[0];
        REG_SIGNED_MODE:    cfg.signed_mode    <= cfg_data[0];
        REG_SCALE_FACTOR:   cfg.scale_factor   <= $signed(cfg_data[31:0]);
        REG_SCALE_OFFSET:   cfg.scale_offset   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  csus_extract #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_extract (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .payload  (s_tdata),
    .out_valid(ex_valid),
    .out_ready(ex_ready),
    .raw_value(ex_raw)
  );

  csus_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (ex_valid),
    .in_ready (ex_ready),
    .raw_in   (ex_raw),
    .out_valid(mac_valid),
    .out_ready(mac_ready),
    .raw_out  (mac_raw),
    .sum      (mac_sum)
  );

  // Stage 6: saturate to the signed 64-bit range
  assign en6       = !v6 || m_tready;
  assign mac_ready = en6;

  always_comb begin
    sat_next = !((&mac_sum[SUM_W-1:63]) || !(|mac_sum[SUM_W-1:63]));
    if (!sat_next) begin
      phys_next = mac_sum[63:0];
    end else if (mac_sum[SUM_W-1]) begin
      phys_next = PHYS_MIN;
    end else begin
      phys_next = PHYS_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en6) begin
      v6 <= mac_valid;
    end
    if (en6 && mac_valid) begin
      raw_value    <= mac_raw;
      scaled_value <= phys_next;
      saturated    <= sat_next;
    end
  end

  assign m_tvalid = v6;
  assign m_tdata  = {scaled_value, raw_value};
  assign m_tuser  = saturated;

  // A clipped result sits exactly at one of the range limits
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[127:64] == PHYS_MIN) || (m_tdata[127:64] == PHYS_MAX))
    else $error("saturated beat not at a range limit");

  // Input backpressure only when every stage is full and the output stalls
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled while pipeline has room");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

/* dv/tb_can_signal_unpack_scale_unit.sv */
// Testbench for can_signal_unpack_scale_unit: random and directed frames with
// predicted raw and scaled values, checked beat by beat on the output stream.
// Depends on csus_pkg and the RTL of the block only.
module tb_can_signal_unpack_scale_unit;
  import csus_pkg::*;

  // Indexes past the register list; writes there must be ignored
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [63:0] raw_value;
    logic [63:0] scaled_value;
    logic        saturated;
  } signal_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wr_en = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;   // [63:0] payload
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;        // [63:0] raw_value, [127:64] scaled_value
  logic [0:0]   m_tuser;        // [0] saturated

  cfg_t           cfg_shadow;
  logic [63:0]    pending_frames[$];
  signal_result_t expected_results[$];
  signal_result_t head_result;
  int             mismatch_count = 0;
  int             send_gap = 0;
  int             send_calm = 0;
  int             sink_stall = 0;
  int             sink_calm = 0;
  bit             frame_taken = 1'b0;

  can_signal_unpack_scale_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("can_signal_unpack_scale_unit: mismatch");
    $finish;
  end

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Append one frame to the send queue
  task automatic queue_frame(logic [63:0] frame);
    pending_frames.insert(pending_frames.size(), frame);
  endtask

  // Gap length: mostly zero or short, a few long, with calm stretches of no gaps
  function automatic int pick_gap(ref int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) calm_left = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Signal extraction, sign handling and exact scaling with saturation
  function automatic signal_result_t predict_signal(logic [63:0] payload);
    logic [63:0]        bits;
    logic [63:0]        sign_mask;
    int                 sbyte;
    int                 sbit;
    int                 len;
    int                 i;
    int                 sh;
    logic signed [64:0] raw_wide;
    logic signed [97:0] product;
    logic signed [97:0] total;
    signal_result_t     r;
    sbyte = cfg_shadow.start_bit[5:3];
    sbit  = cfg_shadow.start_bit[2:0];
    if (!cfg_shadow.motorola_order) begin
      // Intel: higher bytes sit at higher weights, bits past the frame are zero
      bits = payload >> cfg_shadow.start_bit;
    end else begin
      // Motorola: continue into lower-indexed bytes
      bits = ((payload >> (8 * sbyte)) & 64'hff) >> sbit;
      sh = 8 - sbit;
      for (i = sbyte - 1; i >= 0; i--) begin
        bits |= ((payload >> (8 * i)) & 64'hff) << sh;
        sh += 8;
      end
    end
    len = (cfg_shadow.bit_length > 7'd64) ? 64 : int'(cfg_shadow.bit_length);
    if (len == 0) begin
      bits = '0;
    end else begin
      if (len < 64) bits &= ALL_ONES >> (64 - len);
      if (cfg_shadow.signed_mode) begin
        sign_mask = 64'd1 << (len - 1);
        bits = (bits ^ sign_mask) - sign_mask;
      end
    end
    raw_wide = cfg_shadow.signed_mode ? {bits[63], bits} : {1'b0, bits};
    product  = raw_wide * cfg_shadow.scale_factor;
    total    = product + cfg_shadow.scale_offset;
    r.raw_value = bits;
    if ((&total[97:63]) || !(|total[97:63])) begin
      r.scaled_value = total[63:0];
      r.saturated    = 1'b0;
    end else begin
      r.scaled_value = total[97] ? PHYS_MIN : PHYS_MAX;
      r.saturated    = 1'b1;
    end
    return r;
  endfunction

  // Output check first, then input acceptance, so one edge never races itself
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("output beat %h with nothing expected", m_tdata));
      end else begin
        head_result = expected_results.pop_front();
        if (m_tdata[63:0] !== head_result.raw_value)
          report_mismatch($sformatf("raw_value got %h want %h",
                                    m_tdata[63:0], head_result.raw_value));
        if (m_tdata[127:64] !== head_result.scaled_value)
          report_mismatch($sformatf("scaled_value got %h want %h",
                                    m_tdata[127:64], head_result.scaled_value));
        if (m_tuser[0] !== head_result.saturated)
          report_mismatch($sformatf("saturated got %b want %b",
                                    m_tuser[0], head_result.saturated));
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      expected_results.insert(expected_results.size(), predict_signal(s_tdata));
      frame_taken = 1'b1;
    end
  end

  // Input driver: next frame after each accepted beat, with random gaps
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || frame_taken)) begin
      frame_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_frames.size() != 0) begin
        s_tdata  <= pending_frames.pop_front();
        s_tvalid <= 1'b1;
        send_gap = pick_gap(send_calm);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output side backpressure
  always @(negedge clk) begin
    if (!rst) begin
      if (sink_stall > 0) begin
        sink_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        sink_stall = pick_gap(sink_calm);
      end
    end
  end

  // One register write; upper data bits carry junk that the block must mask
  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_START_BIT:      cfg_shadow.start_bit      = value[5:0];
      REG_BIT_LENGTH:     cfg_shadow.bit_length     = value[6:0];
      REG_MOTOROLA_ORDER: cfg_shadow.motorola_order = value[0];
      REG_SIGNED_MODE:    cfg_shadow.signed_mode    = value[0];
      REG_SCALE_FACTOR:   cfg_shadow.scale_factor   = value[31:0];
      REG_SCALE_OFFSET:   cfg_shadow.scale_offset   = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(logic [5:0] sb, logic [6:0] len, bit moto, bit sgn,
                            logic [31:0] factor, logic [63:0] offset);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_START_BIT, {junk[63:6], sb});
    write_reg(REG_BIT_LENGTH, {junk[62:6], len});
    write_reg(REG_MOTOROLA_ORDER, {junk[63:1], moto});
    write_reg(REG_SIGNED_MODE, {junk[60:0], junk[63:62], sgn});
    write_reg(REG_SCALE_FACTOR, {junk[63:32], factor});
    write_reg(REG_SCALE_OFFSET, offset);
  endtask

  // Block until every frame is accepted and every result checked; sampled at
  // the rising edge, where the driven inputs are settled
  task automatic wait_idle();
    while (pending_frames.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_factor();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'h0001_0000;
      4: return 32'hffff_0000;
      5: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_offset();
    case ($urandom_range(0, 5))
      0: return PHYS_MAX;
      1: return PHYS_MIN;
      2: return 64'd0;
      3: return 64'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [6:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 7'd0;
    if (r < 16) return 7'($urandom_range(65, 127));
    if (r < 28) return 7'd64;
    return 7'($urandom_range(1, 63));
  endfunction

  function automatic logic [63:0] pick_payload();
    logic [63:0] one_hot;
    one_hot = 64'd1 << $urandom_range(0, 63);
    case ($urandom_range(0, 19))
      0: return 64'd0;
      1: return ALL_ONES;
      2: return one_hot;
      3: return ~one_hot;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    cfg_shadow.start_bit      = 6'd0;
    cfg_shadow.bit_length     = 7'd8;
    cfg_shadow.motorola_order = 1'b0;
    cfg_shadow.signed_mode    = 1'b0;
    cfg_shadow.scale_factor   = 32'sd65536;
    cfg_shadow.scale_offset   = 64'sd0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: low byte, unsigned, factor 1.0
    queue_frame(64'd0);
    queue_frame(ALL_ONES);
    queue_frame(64'h0123_4567_89ab_cdef);
    queue_frame(64'h0000_0000_0000_0080);
    wait_idle();

    // Full-width signed value, largest factor: minus one, then saturation low and high
    set_config(6'd0, 7'd64, 1'b0, 1'b1, 32'h7fff_ffff, 64'd0);
    queue_frame(ALL_ONES);
    queue_frame(PHYS_MIN);
    queue_frame(PHYS_MAX);
    wait_idle();

    // Unsigned full-width raw times most negative factor, largest offset
    set_config(6'd0, 7'd64, 1'b0, 1'b0, 32'h8000_0000, PHYS_MAX);
    queue_frame(ALL_ONES);
    queue_frame(64'd1);
    wait_idle();

    // Zero length: raw is empty, result is the offset
    set_config(6'd13, 7'd0, 1'b1, 1'b1, 32'h0001_0000, PHYS_MIN);
    queue_frame(64'h5a5a_5a5a_5a5a_5a5a);
    queue_frame(ALL_ONES);
    wait_idle();

    // Length above 64, Motorola from the top bit
    set_config(6'd63, 7'd127, 1'b1, 1'b1, 32'hffff_0000, 64'h1234);
    queue_frame(ALL_ONES);
    queue_frame(PHYS_MIN);
    queue_frame(64'h00ff_00ff_00ff_00ff);
    wait_idle();

    // Intel signal running off the end of the frame
    set_config(6'd60, 7'd16, 1'b0, 1'b1, 32'h0003_0000, 64'hffff_ffff_ffff_fffb);
    queue_frame(ALL_ONES);
    queue_frame(64'hf000_0000_0000_0000);
    wait_idle();

    // Motorola mid-frame, unsigned; writes past the register list are ignored
    set_config(6'd39, 7'd24, 1'b1, 1'b0, 32'h0000_0001, PHYS_MIN);
    write_reg(REG_SPARE_6, ALL_ONES);
    write_reg(REG_SPARE_7, ALL_ONES);
    queue_frame(64'h0123_4567_89ab_cdef);
    queue_frame(ALL_ONES);
    wait_idle();

    // Random settings, each with a batch of random frames
    for (int phase = 0; phase < 13; phase++) begin
      set_config(6'($urandom_range(0, 63)), pick_length(), $urandom_range(0, 1),
                 $urandom_range(0, 1), pick_factor(), pick_offset());
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE_6, {$urandom, $urandom});
      for (int k = 0; k < 50; k++) queue_frame(pick_payload());
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("can_signal_unpack_scale_unit: match");
    end else begin
      $display("can_signal_unpack_scale_unit: mismatch");
    end
    $finish;
  end

endmodule
